[hdl/ffl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ffl_pkg;

   localparam int FLAG_W       = 15;
   localparam int WORD_W       = 32;
   localparam int ADDR_WORD_W  = 12;
   localparam int SUM_W        = 13;
   localparam int RECORD_COUNT = 4;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 10;

   localparam logic [1:0] OP_SCAN  = 2'd0;
   localparam logic [1:0] OP_UNDO  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic KIND_EVENT = 1'b0;
   localparam logic KIND_UNDO  = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_REC0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_REC1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_REC2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_REC3 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_REC0  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_REC1  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_REC2  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_REC3  = 3'd7;

   typedef logic [2:0] width_cfg_type;
   typedef logic [9:0] base_cfg_type;

   localparam width_cfg_type WIDTH_RESET [4] = '{3'd4, 3'd4, 3'd4, 3'd1};
   localparam base_cfg_type  BASE_RESET  [4] = '{10'd0, 10'd64, 10'd72, 10'd672};

   typedef struct packed {
      logic [1:0]        rec;
      logic [FLAG_W-1:0] flag;
      logic              val;
   } log_entry_type;

   typedef struct packed {
      logic                   valid;
      base_cfg_type           base;
      logic [ADDR_WORD_W-1:0] word;
   } addr_req_type;

   // log2 of the word width in bits; zero when the byte count is not 1, 2 or 4
   function automatic logic [2:0] width_shift(input width_cfg_type w);
      logic [2:0] s;
      case (w)
         3'd1:    s = 3'd3;
         3'd2:    s = 3'd4;
         3'd4:    s = 3'd5;
         default: s = 3'd0;
      endcase
      return s;
   endfunction

   function automatic logic [WORD_W-1:0] width_mask(input logic [2:0] s);
      logic [WORD_W-1:0] m;
      case (s)
         3'd3:    m = 32'h0000_00FF;
         3'd4:    m = 32'h0000_FFFF;
         3'd5:    m = 32'hFFFF_FFFF;
         default: m = 32'h0000_0000;
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

[hdl/flag_change_event_logger.sv]
`timescale 1ns / 1ps
`default_nettype none
// Scan: one result per changed bit, after the shadow address modulo unit
//   (sum, quotient and address registers) and the shadow read; busy until
//   the walk reaches the highest changed bit. Start is ignored while busy.
// Undo: result after the log read; busy until the shadow bit is written back.
// Clear does not raise busy. Reset: busy while the shadow store is zeroed;
//   config writes are taken meanwhile. Results cannot be stalled.
module flag_change_event_logger #(
   parameter int SHADOW_WORDS = 1024,
   parameter int LOG_DEPTH    = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [1:0]                        req_op,
   input  wire logic [1:0]                        req_rec_sel,
   input  wire logic [9:0]                        req_word_index,
   input  wire logic [ffl_pkg::WORD_W-1:0]        req_word_value,
   output logic                                   rsp_valid,
   output logic                                   rsp_kind,
   output logic [1:0]                             rsp_out_record,
   output logic [ffl_pkg::FLAG_W-1:0]             rsp_flag_number,
   output logic                                   rsp_flag_value,
   output logic                                   rsp_last,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ffl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [ffl_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ffl_pkg::*;

   localparam int AW    = $clog2(SHADOW_WORDS);
   localparam int HW    = $clog2(LOG_DEPTH > 1 ? LOG_DEPTH : 2);
   localparam int CNT_W = $clog2(LOG_DEPTH + 1);
   localparam int LW    = $bits(log_entry_type);

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_ADDR  = 3'd2;
   localparam logic [2:0] ST_DIFF  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;
   localparam logic [2:0] ST_LREAD = 3'd5;
   localparam logic [2:0] ST_LDATA = 3'd6;

   width_cfg_type width_ff [4];
   width_cfg_type width_in [4];
   base_cfg_type  base_ff  [4];
   base_cfg_type  base_in  [4];

   logic [2:0]        state_ff, state_in;
   logic [AW-1:0]     init_cnt_ff, init_cnt_in;
   logic [HW-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              is_undo_ff, is_undo_in;
   logic [1:0]        rec_ff, rec_in;
   logic [WORD_W-1:0] live_ff, live_in;
   logic [WORD_W-1:0] mask_ff, mask_in;
   logic [WORD_W-1:0] diff_ff, diff_in;
   logic [FLAG_W-1:0] flag_ff, flag_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [4:0]        bitsel_ff, bitsel_in;
   logic              nval_ff, nval_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [1:0]        rsp_rec_ff, rsp_rec_in;
   logic [FLAG_W-1:0] rsp_flag_ff, rsp_flag_in;
   logic              rsp_val_ff, rsp_val_in;
   logic              rsp_last_ff, rsp_last_in;

   addr_req_type      addr_req;
   logic              addr_done;
   logic [AW-1:0]     addr_res;

   logic              sh_we;
   logic [AW-1:0]     sh_waddr;
   logic [WORD_W-1:0] sh_wdata;
   logic [WORD_W-1:0] sh_rdata;
   logic              lg_we;
   log_entry_type     lg_wdata;
   log_entry_type     lg_rdata;

   logic [2:0]        req_shift;
   logic [2:0]        ent_shift;
   logic [5:0]        bit_lim;
   logic              rec_ok;
   logic [HW-1:0]     head_inc;
   logic [HW-1:0]     head_dec;
   logic [WORD_W-1:0] diff_new;
   logic [WORD_W-1:0] bit_onehot;

   ffl_addr #(.SHADOW_WORDS(SHADOW_WORDS)) u_addr (
      .clock (clock),
      .reset (reset),
      .req   (addr_req),
      .done  (addr_done),
      .addr  (addr_res)
   );

   ffl_ram #(.WIDTH(WORD_W), .DEPTH(SHADOW_WORDS)) u_shadow (
      .clock   (clock),
      .wr_en   (sh_we),
      .wr_addr (sh_waddr),
      .wr_data (sh_wdata),
      .rd_addr (addr_res),
      .rd_data (sh_rdata)
   );

   ffl_ram #(.WIDTH(LW), .DEPTH(LOG_DEPTH)) u_log (
      .clock   (clock),
      .wr_en   (lg_we),
      .wr_addr (head_ff),
      .wr_data (lg_wdata),
      .rd_addr (head_ff),
      .rd_data (lg_rdata)
   );

   assign csr_ready = 1'b1;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         width_in[i] = width_ff[i];
         base_in[i]  = base_ff[i];
      end
      if (csr_valid) begin
         case (csr_index)
            CSR_WIDTH_REC0: width_in[0] = csr_wdata[2:0];
            CSR_WIDTH_REC1: width_in[1] = csr_wdata[2:0];
            CSR_WIDTH_REC2: width_in[2] = csr_wdata[2:0];
            CSR_WIDTH_REC3: width_in[3] = csr_wdata[2:0];
            CSR_BASE_REC0:  base_in[0]  = csr_wdata;
            CSR_BASE_REC1:  base_in[1]  = csr_wdata;
            CSR_BASE_REC2:  base_in[2]  = csr_wdata;
            CSR_BASE_REC3:  base_in[3]  = csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_shift  = width_shift(width_ff[req_rec_sel]);
   assign ent_shift  = width_shift(width_ff[lg_rdata.rec]);
   assign bit_lim    = (6'd1 << ent_shift) - 6'd1;
   assign rec_ok     = {1'b0, req_rec_sel} < 3'(RECORD_COUNT);
   assign head_inc   = (head_ff == HW'(LOG_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign head_dec   = (head_ff == '0) ? HW'(LOG_DEPTH - 1) : head_ff - 1'b1;
   assign diff_new   = (live_ff ^ sh_rdata) & mask_ff;
   assign bit_onehot = WORD_W'(1) << bitsel_ff;

   always_comb begin
      state_in     = state_ff;
      init_cnt_in  = init_cnt_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      is_undo_in   = is_undo_ff;
      rec_in       = rec_ff;
      live_in      = live_ff;
      mask_in      = mask_ff;
      diff_in      = diff_ff;
      flag_in      = flag_ff;
      addr_in      = addr_ff;
      bitsel_in    = bitsel_ff;
      nval_in      = nval_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_rec_in   = rsp_rec_ff;
      rsp_flag_in  = rsp_flag_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_last_in  = rsp_last_ff;
      addr_req     = '0;
      sh_we        = 1'b0;
      sh_waddr     = addr_ff;
      sh_wdata     = live_ff;
      lg_we        = 1'b0;
      lg_wdata     = '{rec: rec_ff, flag: flag_ff, val: live_ff[0]};

      case (state_ff)
         ST_INIT: begin
            sh_we    = 1'b1;
            sh_waddr = init_cnt_ff;
            sh_wdata = '0;
            if (init_cnt_ff == AW'(SHADOW_WORDS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               init_cnt_in = init_cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               case (req_op)
                  OP_SCAN: begin
                     is_undo_in = 1'b0;
                     rec_in     = req_rec_sel;
                     mask_in    = width_mask(req_shift);
                     live_in    = req_word_value & width_mask(req_shift);
                     flag_in    = FLAG_W'(req_word_index) << req_shift;
                     if (rec_ok && req_shift != 3'd0) begin
                        addr_req.valid = 1'b1;
                        addr_req.base  = base_ff[req_rec_sel];
                        addr_req.word  = ADDR_WORD_W'(req_word_index);
                        state_in       = ST_ADDR;
                     end
                  end
                  OP_UNDO: begin
                     if (count_ff != '0) begin
                        head_in  = head_dec;
                        count_in = count_ff - 1'b1;
                        state_in = ST_LREAD;
                     end
                  end
                  OP_CLEAR: begin
                     head_in  = '0;
                     count_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_ADDR: begin
            if (addr_done) begin
               addr_in  = addr_res;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            sh_we = 1'b1;
            if (is_undo_ff) begin
               sh_wdata = nval_ff ? (sh_rdata | bit_onehot) : (sh_rdata & ~bit_onehot);
               state_in = ST_IDLE;
            end else begin
               diff_in  = diff_new;
               state_in = (diff_new != '0) ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (diff_ff[0]) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_EVENT;
               rsp_rec_in   = rec_ff;
               rsp_flag_in  = flag_ff;
               rsp_val_in   = live_ff[0];
               rsp_last_in  = (diff_ff[WORD_W-1:1] == '0);
               lg_we        = 1'b1;
               head_in      = head_inc;
               if (count_ff != CNT_W'(LOG_DEPTH)) begin
                  count_in = count_ff + 1'b1;
               end
            end
            diff_in = diff_ff >> 1;
            live_in = live_ff >> 1;
            flag_in = flag_ff + 1'b1;
            if (diff_ff[WORD_W-1:1] == '0) begin
               state_in = ST_IDLE;
            end
         end
         ST_LREAD: begin
            state_in = ST_LDATA;
         end
         ST_LDATA: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_UNDO;
            rsp_rec_in   = lg_rdata.rec;
            rsp_flag_in  = lg_rdata.flag;
            rsp_val_in   = ~lg_rdata.val;
            rsp_last_in  = 1'b1;
            is_undo_in   = 1'b1;
            nval_in      = ~lg_rdata.val;
            bitsel_in    = lg_rdata.flag[4:0] & bit_lim[4:0];
            if (ent_shift != 3'd0) begin
               addr_req.valid = 1'b1;
               addr_req.base  = base_ff[lg_rdata.rec];
               addr_req.word  = ADDR_WORD_W'(lg_rdata.flag >> ent_shift);
               state_in       = ST_ADDR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_cnt_ff  <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            width_ff[i] <= WIDTH_RESET[i];
            base_ff[i]  <= BASE_RESET[i];
         end
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 4; i++) begin
            width_ff[i] <= width_in[i];
            base_ff[i]  <= base_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      is_undo_ff  <= is_undo_in;
      rec_ff      <= rec_in;
      live_ff     <= live_in;
      mask_ff     <= mask_in;
      diff_ff     <= diff_in;
      flag_ff     <= flag_in;
      addr_ff     <= addr_in;
      bitsel_ff   <= bitsel_in;
      nval_ff     <= nval_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_rec_ff  <= rsp_rec_in;
      rsp_flag_ff <= rsp_flag_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_out_record  = rsp_rec_ff;
   assign rsp_flag_number = rsp_flag_ff;
   assign rsp_flag_value  = rsp_val_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_undo_pops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start && req_op == OP_UNDO && count_ff != '0)
      |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("undo did not pop the log");

   a_undo_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_UNDO) |-> rsp_last)
      else $error("undo write-back not marked last");

   a_event_src: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_EVENT) |-> ($past(state_ff) == ST_EMIT))
      else $error("change event outside the emit walk");

   a_init_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT) |-> (!rsp_valid && busy))
      else $error("activity during shadow clear");
`endif

endmodule
`default_nettype wire

[hdl/ffl_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module ffl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

[hdl/ffl_addr.sv]
`timescale 1ns / 1ps
`default_nettype none
module ffl_addr #(
   parameter int SHADOW_WORDS = 1024
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire ffl_pkg::addr_req_type           req,
   output logic                                 done,
   output logic [$clog2(SHADOW_WORDS)-1:0]      addr
);
   import ffl_pkg::*;

   localparam int AW = $clog2(SHADOW_WORDS);
   localparam int KS = SUM_W + AW;
   localparam int MW = KS - 3;
   localparam int PW = SUM_W + MW;
   localparam int QW = PW - KS;
   localparam int CW = SUM_W + AW + 1;
   localparam logic [MW-1:0] RECIP = MW'((64'd1 << KS) / SHADOW_WORDS);

   logic [1:0]       valid_ff;
   logic             done_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;
   logic [SUM_W-1:0] sum2_ff;
   logic [QW-1:0]    q_ff;
   logic [QW-1:0]    q_in;
   logic [PW-1:0]    prod;
   logic [CW-1:0]    qn;
   logic [CW-1:0]    rem;
   logic [CW-1:0]    rem_fix;
   logic [AW-1:0]    addr_ff;
   logic [AW-1:0]    addr_in;

   // (base + word) mod SHADOW_WORDS: reciprocal multiply, then one correction
   assign sum_in  = SUM_W'(req.base) + SUM_W'(req.word);
   assign prod    = PW'(sum_ff) * PW'(RECIP);
   assign q_in    = prod[PW-1:KS];
   assign qn      = CW'(q_ff) * CW'(SHADOW_WORDS);
   assign rem     = CW'(sum2_ff) - qn;
   assign rem_fix = (rem >= CW'(SHADOW_WORDS)) ? rem - CW'(SHADOW_WORDS) : rem;
   assign addr_in = rem_fix[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         valid_ff <= {valid_ff[0], req.valid};
         done_ff  <= valid_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      sum2_ff <= sum_ff;
      q_ff    <= q_in;
      addr_ff <= addr_in;
   end

   assign done = done_ff;
   assign addr = addr_ff;

endmodule
`default_nettype wire
